// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Every property is sampled on the rising edge; JIC_ASSERT is off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is disabled during reset.
`define JIC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that is also checked while reset is low.
`define JIC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/jic_pkg.sv =====
// ---------------------------------------------------------------------------
// jic_pkg
// Types and constants of the joystick input conditioner.
// ---------------------------------------------------------------------------
package jic_pkg;

  localparam int ButtonCount = 8;
  localparam int ScanCount   = (ButtonCount < 8) ? ButtonCount : 8;
  localparam logic [7:0] ScanMask = 8'((9'd1 << ScanCount) - 9'd1);

  localparam int InDataW  = 48;
  localparam int OutDataW = 48;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  typedef enum logic [1:0] {
    OP_POSITION = 2'd0,
    OP_ARROW    = 2'd1,
    OP_NOTIFY   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ARROW_UP    = 2'd0,
    ARROW_DOWN  = 2'd1,
    ARROW_LEFT  = 2'd2,
    ARROW_RIGHT = 2'd3
  } arrow_e;

  typedef enum logic {
    EV_POSITION = 1'b0,
    EV_BUTTON   = 1'b1
  } event_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DZ_LOW  = 3'd0,
    CFG_DZ_HIGH = 3'd1,
    CFG_POS_MIN = 3'd2,
    CFG_POS_MAX = 3'd3,
    CFG_TAG     = 3'd4
  } cfg_idx_e;

  // Arrow flag bits: up held, down held, down pressed last, left held,
  // right held, right pressed last.
  localparam int FlagUp        = 0;
  localparam int FlagDown      = 1;
  localparam int FlagDownLast  = 2;
  localparam int FlagLeft      = 4;
  localparam int FlagRight     = 5;
  localparam int FlagRightLast = 6;
  localparam logic [6:0] FlagsAnyHeld = 7'h33;

  localparam logic signed [15:0] DzLowReset  = -16'sd50;
  localparam logic signed [15:0] DzHighReset = 16'sd50;
  localparam logic signed [15:0] PosMinReset = -16'sd1000;
  localparam logic signed [15:0] PosMaxReset = 16'sd1000;

  typedef struct packed {
    logic signed [15:0] dz_low;
    logic signed [15:0] dz_high;
    logic signed [15:0] pos_min;
    logic signed [15:0] pos_max;
  } cond_cfg_t;

endpackage

// ===== src/jic_cond.sv =====
// ---------------------------------------------------------------------------
// jic_cond
// Axis conditioner: dead zone and limit clipping on one shared comparator.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module jic_cond (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  jic_pkg::cond_cfg_t       cfg_i,
  input  logic                     start_i,
  input  logic signed [15:0]       value_i,
  output logic                     done_o,
  output logic signed [15:0]       result_o
);
  import jic_pkg::*;

  typedef enum logic [2:0] {
    C_IDLE,
    C_DZL,
    C_DZH,
    C_MIN,
    C_MAX
  } cstate_e;

  cstate_e            state_q;
  logic signed [15:0] val_q;
  logic               lo_ok_q;
  logic               done_q;
  logic signed [15:0] result_q;

  logic signed [15:0] op_a;
  logic signed [15:0] op_b;
  logic               lt;

  // The single comparator; each step picks its operands.
  always_comb begin
    unique case (state_q)
      C_DZL: begin
        op_a = val_q;
        op_b = cfg_i.dz_low;
      end
      C_DZH: begin
        op_a = cfg_i.dz_high;
        op_b = val_q;
      end
      C_MIN: begin
        op_a = val_q;
        op_b = cfg_i.pos_min;
      end
      C_MAX: begin
        op_a = cfg_i.pos_max;
        op_b = val_q;
      end
      default: begin
        op_a = val_q;
        op_b = val_q;
      end
    endcase
  end

  assign lt = (op_a < op_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= C_IDLE;
      done_q   <= 1'b0;
      lo_ok_q  <= 1'b0;
      val_q    <= '0;
      result_q <= '0;
    end else begin
      done_q <= (state_q == C_MAX) || ((state_q == C_MIN) && lt);
      unique case (state_q)
        C_IDLE: begin
          if (start_i) begin
            val_q   <= value_i;
            state_q <= C_DZL;
          end
        end
        C_DZL: begin
          lo_ok_q <= !lt;
          state_q <= C_DZH;
        end
        C_DZH: begin
          if (lo_ok_q && !lt) begin
            val_q <= '0;
          end
          state_q <= C_MIN;
        end
        C_MIN: begin
          if (lt) begin
            result_q <= cfg_i.pos_min;
            state_q  <= C_IDLE;
          end else begin
            state_q <= C_MAX;
          end
        end
        C_MAX: begin
          result_q <= lt ? cfg_i.pos_max : val_q;
          state_q  <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  `JIC_ASSERT(a_done_pulse, done_o |=> !done_o, "jic_cond: done held for two cycles")
  `JIC_ASSERT(a_start_idle, start_i |-> (state_q == C_IDLE), "jic_cond: start while busy")

endmodule

// ===== src/joystick_input_conditioner_top.sv =====
// ---------------------------------------------------------------------------
// joystick_input_conditioner_top
// Joystick conditioner: axis shaping, arrow overrides and change events.
// ---------------------------------------------------------------------------
//   channel  | direction | handshake                     | payload
//   s_axis   | in        | s_axis_tvalid_i/tready_o      | tuser opcode, tdata item
//   m_axis   | out       | m_axis_tvalid_o/tready_i      | tuser kind, tdata, tlast
//   cfg      | in        | cfg_we_i (no back-pressure)   | cfg_index_i, cfg_data_i
//
// A position word runs each axis, x first, through the shared comparator
// unit: load, low and high dead-zone bound, minimum, and the maximum unless
// the minimum already clipped; after the y axis the sequencer goes idle.
// An arrow word updates the arrow flags while the sequencer stays idle. A
// notify word is accepted, then the position is checked, then each button
// in the scan is visited in turn, then the scan finishes; stalls on m_axis
// can lengthen it. Output back-pressure only stalls the sequencer when a
// new event must be loaded into the full output register.
// Reset is asynchronous and active low and restores all state at once.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module joystick_input_conditioner_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // From bit 0: axis_x[15:0], axis_y[31:16], arrow[33:32], key_down[34],
  // button_mask[42:35], zero padding [47:43].
  input  logic [jic_pkg::InDataW-1:0]   s_axis_tdata_i,
  // opcode[1:0].
  input  logic [1:0]                    s_axis_tuser_i,
  // Output stream.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // From bit 0: event_tag[7:0], report_x[23:8], report_y[39:24],
  // button_index[42:40], button_state[43], zero padding [47:44].
  output logic [jic_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // event_kind[0].
  output logic                          m_axis_tuser_o,
  // last_event.
  output logic                          m_axis_tlast_o,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [jic_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [jic_pkg::CfgDataW-1:0]  cfg_data_i
);
  import jic_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COND_X,
    ST_COND_Y,
    ST_POS,
    ST_SCAN
  } state_e;

  // Configuration registers.
  cond_cfg_t  cfg_q;
  logic [7:0] tag_q;

  // Joystick state.
  logic signed [15:0] held_x_q;
  logic signed [15:0] held_y_q;
  logic        [6:0]  flags_q;
  logic signed [15:0] rep_x_q;
  logic signed [15:0] rep_y_q;
  logic        [7:0]  rep_btn_q;

  // Sequencer state.
  state_e             state_q;
  logic signed [15:0] pend_y_q;
  logic        [7:0]  mask_q;
  logic        [7:0]  changed_q;
  logic        [3:0]  idx_q;

  // Output register.
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic                out_kind_q;
  logic                out_last_q;

  // Input word fields.
  logic signed [15:0] in_x;
  logic signed [15:0] in_y;
  logic        [1:0]  in_arrow;
  logic               in_down;
  logic        [7:0]  in_mask;
  logic               in_accept;

  assign in_x      = s_axis_tdata_i[15:0];
  assign in_y      = s_axis_tdata_i[31:16];
  assign in_arrow  = s_axis_tdata_i[33:32];
  assign in_down   = s_axis_tdata_i[34];
  assign in_mask   = s_axis_tdata_i[42:35];
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = (state_q == ST_IDLE);

  // The conditioning unit is shared by both axes, x first.
  logic               cond_start;
  logic signed [15:0] cond_value;
  logic               cond_done;
  logic signed [15:0] cond_result;

  assign cond_start = (in_accept && (s_axis_tuser_i == OP_POSITION)) ||
                      ((state_q == ST_COND_X) && cond_done);
  assign cond_value = (state_q == ST_IDLE) ? in_x : pend_y_q;

  jic_cond u_cond (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .start_i  (cond_start),
    .value_i  (cond_value),
    .done_o   (cond_done),
    .result_o (cond_result)
  );

  // Held arrows override the held position. When both keys of an axis are
  // held, the one that went down last wins.
  logic signed [15:0] eff_x;
  logic signed [15:0] eff_y;

  always_comb begin
    eff_x = held_x_q;
    eff_y = held_y_q;
    if ((flags_q & FlagsAnyHeld) != '0) begin
      unique case ({flags_q[FlagDown], flags_q[FlagUp]})
        2'b00:   eff_y = '0;
        2'b01:   eff_y = cfg_q.pos_min;
        2'b10:   eff_y = cfg_q.pos_max;
        default: eff_y = flags_q[FlagDownLast] ? cfg_q.pos_max : cfg_q.pos_min;
      endcase
      unique case ({flags_q[FlagRight], flags_q[FlagLeft]})
        2'b00:   eff_x = '0;
        2'b01:   eff_x = cfg_q.pos_min;
        2'b10:   eff_x = cfg_q.pos_max;
        default: eff_x = flags_q[FlagRightLast] ? cfg_q.pos_max : cfg_q.pos_min;
      endcase
    end
  end

  logic       out_free;
  logic       out_load;
  logic       pos_diff;
  logic [2:0] btn_idx;
  logic [7:0] btn_bit;
  logic [7:0] changed_rest;

  assign out_free     = !out_valid_q || m_axis_tready_i;
  assign pos_diff     = (eff_x != rep_x_q) || (eff_y != rep_y_q);
  assign btn_idx      = idx_q[2:0];
  assign btn_bit      = 8'd1 << btn_idx;
  assign changed_rest = changed_q & ~btn_bit;

  // A new event enters the output register in this cycle.
  assign out_load = out_free &&
                    (((state_q == ST_POS) && pos_diff) ||
                     ((state_q == ST_SCAN) && (idx_q != 4'(ScanCount)) &&
                      changed_q[btn_idx]));

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dz_low  <= DzLowReset;
      cfg_q.dz_high <= DzHighReset;
      cfg_q.pos_min <= PosMinReset;
      cfg_q.pos_max <= PosMaxReset;
      tag_q         <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DZ_LOW:  cfg_q.dz_low  <= cfg_data_i;
        CFG_DZ_HIGH: cfg_q.dz_high <= cfg_data_i;
        CFG_POS_MIN: cfg_q.pos_min <= cfg_data_i;
        CFG_POS_MAX: cfg_q.pos_max <= cfg_data_i;
        CFG_TAG:     tag_q         <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer, joystick state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_x_q    <= '0;
      held_y_q    <= '0;
      flags_q     <= '0;
      rep_x_q     <= '0;
      rep_y_q     <= '0;
      rep_btn_q   <= '0;
      pend_y_q    <= '0;
      mask_q      <= '0;
      changed_q   <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_kind_q  <= EV_POSITION;
      out_last_q  <= 1'b0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && !m_axis_tready_i);
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            unique case (s_axis_tuser_i)
              OP_POSITION: begin
                pend_y_q <= in_y;
                state_q  <= ST_COND_X;
              end
              OP_ARROW: begin
                unique case (arrow_e'(in_arrow))
                  ARROW_UP: begin
                    flags_q[FlagUp] <= in_down;
                    if (in_down) flags_q[FlagDownLast] <= 1'b0;
                  end
                  ARROW_DOWN: begin
                    flags_q[FlagDown] <= in_down;
                    if (in_down) flags_q[FlagDownLast] <= 1'b1;
                  end
                  ARROW_LEFT: begin
                    flags_q[FlagLeft] <= in_down;
                    if (in_down) flags_q[FlagRightLast] <= 1'b0;
                  end
                  default: begin
                    flags_q[FlagRight] <= in_down;
                    if (in_down) flags_q[FlagRightLast] <= 1'b1;
                  end
                endcase
              end
              OP_NOTIFY: begin
                mask_q    <= in_mask;
                changed_q <= (rep_btn_q ^ in_mask) & ScanMask;
                state_q   <= ST_POS;
              end
              default: ;
            endcase
          end
        end
        ST_COND_X: begin
          if (cond_done) begin
            held_x_q <= cond_result;
            state_q  <= ST_COND_Y;
          end
        end
        ST_COND_Y: begin
          if (cond_done) begin
            held_y_q <= cond_result;
            state_q  <= ST_IDLE;
          end
        end
        ST_POS: begin
          idx_q <= '0;
          if (!pos_diff) begin
            state_q <= ST_SCAN;
          end else if (out_free) begin
            rep_x_q     <= eff_x;
            rep_y_q     <= eff_y;
            out_kind_q  <= EV_POSITION;
            out_last_q  <= (changed_q == '0);
            out_data_q  <= {8'd0, eff_y, eff_x, tag_q};
            state_q     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (idx_q == 4'(ScanCount)) begin
            state_q <= ST_IDLE;
          end else if (!changed_q[btn_idx]) begin
            idx_q <= idx_q + 4'd1;
          end else if (out_free) begin
            // Emitting clears the bit, so the event whose bit leaves the
            // set empty is the final one.
            rep_btn_q[btn_idx] <= mask_q[btn_idx];
            changed_q          <= changed_rest;
            out_kind_q         <= EV_BUTTON;
            out_last_q         <= (changed_rest == '0);
            out_data_q         <= {4'd0, mask_q[btn_idx], btn_idx, 40'd0};
            idx_q              <= idx_q + 4'd1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  `JIC_ASSERT(a_btn_clean, (m_axis_tvalid_o && (m_axis_tuser_o == EV_BUTTON)) |-> (m_axis_tdata_o[39:0] == '0), "button word carries position data")
  `JIC_ASSERT(a_pos_clean, (m_axis_tvalid_o && (m_axis_tuser_o == EV_POSITION)) |-> (m_axis_tdata_o[47:40] == '0), "position word carries button data")
  `JIC_ASSERT_ALWAYS(a_idx_range, idx_q <= 4'(ScanCount), "button scan index out of range")

endmodule
